// ===== sv/deb_pkg.sv =====
// Shared types and constants for the digitizer event builder.
// Result kinds, header field positions and the structs passed between modules.
// No dependencies.
package deb_pkg;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_TRACE  = 2'd1;
	localparam logic [1:0] KIND_ESUM   = 2'd2;
	localparam logic [1:0] KIND_QDC    = 2'd3;

	localparam logic [13:0] STASH_WORDS     = 14'd3;
	localparam logic [13:0] HEADER_POS      = 14'd3;
	localparam logic [13:0] ESUM_END_POS    = 14'd8;
	localparam logic [13:0] MIN_EVT_LEN     = 14'd4;
	localparam logic [4:0]  MIN_HDR_LEN     = 5'd4;
	localparam logic [4:0]  QDC_ONLY_HDR_LEN = 5'd12;
	localparam logic [31:0] TRACE_MASK      = 32'h3FFF_3FFF;
	localparam logic [31:0] WINDOW_RESET    = 32'd100;

	typedef struct packed {
		logic [11:0] det_id;
		logic        pileup;
		logic [47:0] timestamp;
		logic [14:0] cfd_time;
		logic        cfd_forced;
		logic [15:0] energy;
		logic [13:0] evt_len;
		logic [4:0]  hdr_len;
	} header_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] det_id;
		logic        pileup;
		logic [47:0] timestamp;
		logic [14:0] cfd_time;
		logic        cfd_forced;
		logic [15:0] energy;
		logic        new_event;
		logic        order_error;
		logic [31:0] payload;
		logic        last;
	} result_t;

endpackage

// ===== sv/deb_word_if.sv =====
// Input channel of the event builder: one 32-bit list-mode word per transaction.
// Valid/ready handshake; no dependencies.
interface deb_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;

	modport source (output valid, output data_word, input ready);
	modport sink (input valid, input data_word, output ready);
endinterface

// ===== sv/deb_result_if.sv =====
// Output channel of the event builder: one result record per transaction.
// Valid/ready handshake; no dependencies.
interface deb_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [11:0] det_id;
	logic        pileup;
	logic [47:0] timestamp;
	logic [14:0] cfd_time;
	logic        cfd_forced;
	logic [15:0] energy;
	logic        new_event;
	logic        order_error;
	logic [31:0] payload;
	logic        last;

	modport source (output valid, output kind, output det_id, output pileup,
		output timestamp, output cfd_time, output cfd_forced, output energy,
		output new_event, output order_error, output payload, output last,
		input ready);
	modport sink (input valid, input kind, input det_id, input pileup,
		input timestamp, input cfd_time, input cfd_forced, input energy,
		input new_event, input order_error, input payload, input last,
		output ready);
endinterface

// ===== sv/deb_hdr_decode.sv =====
// Combinational decode of the four header words into detector id, timestamp,
// CFD fields, rebinned energy and effective lengths. Depends on deb_pkg.
module deb_hdr_decode #(
	parameter int BOARDS_PER_CRATE   = 13,
	parameter int CHANNELS_PER_BOARD = 16,
	parameter int FIRST_SLOT         = 2,
	parameter int ENERGY_REBIN       = 1
) (
	input  logic [31:0]      w0,
	input  logic [31:0]      w1,
	input  logic [31:0]      w2,
	input  logic [31:0]      w3,
	output deb_pkg::header_t hdr
);

	localparam logic [11:0] CRATE_STRIDE = 12'(BOARDS_PER_CRATE * CHANNELS_PER_BOARD);
	localparam logic [11:0] SLOT_STRIDE  = 12'(CHANNELS_PER_BOARD);
	localparam logic [11:0] SLOT_OFFSET  = 12'(FIRST_SLOT * CHANNELS_PER_BOARD);
	localparam int          REBIN_SHIFT  = 16 + $clog2(ENERGY_REBIN);
	localparam logic [17:0] REBIN_RECIP  =
		18'(((64'd1 << REBIN_SHIFT) + 64'(ENERGY_REBIN) - 64'd1) / 64'(ENERGY_REBIN));

	logic [3:0]  chn;
	logic [3:0]  sln;
	logic [3:0]  crn;
	logic [4:0]  hl_raw;
	logic [13:0] el_raw;
	logic [13:0] el_eff;
	logic [4:0]  hl_min;
	logic [11:0] crate_term;
	logic [11:0] slot_term;
	logic [33:0] energy_prod;

	assign chn    = w0[3:0];
	assign sln    = w0[7:4];
	assign crn    = w0[11:8];
	assign hl_raw = w0[16:12];
	assign el_raw = w0[30:17];

	assign crate_term = 12'({8'd0, crn} * CRATE_STRIDE);
	assign slot_term  = 12'({8'd0, sln} * SLOT_STRIDE);

	// exact reciprocal scaling for 16-bit operands
	assign energy_prod = 34'(w3[15:0]) * 34'(REBIN_RECIP);

	assign el_eff = (el_raw < deb_pkg::MIN_EVT_LEN) ? deb_pkg::MIN_EVT_LEN : el_raw;
	assign hl_min = (hl_raw < deb_pkg::MIN_HDR_LEN) ? deb_pkg::MIN_HDR_LEN : hl_raw;

	always_comb begin
		hdr.det_id     = crate_term + slot_term - SLOT_OFFSET + {8'd0, chn};
		hdr.pileup     = w0[31];
		hdr.timestamp  = {w2[15:0], w1};
		hdr.cfd_time   = w2[30:16];
		hdr.cfd_forced = w2[31];
		hdr.energy     = 16'(energy_prod >> REBIN_SHIFT);
		hdr.evt_len    = el_eff;
		hdr.hdr_len    = ({9'd0, hl_min} > el_eff) ? el_eff[4:0] : hl_min;
	end

endmodule

// ===== sv/deb_builder.sv =====
// Subevent sequencer and time-window event builder: header stash, word position,
// reference time and build window register. Depends on deb_pkg, deb_hdr_decode.
module deb_builder #(
	parameter int BOARDS_PER_CRATE   = 13,
	parameter int CHANNELS_PER_BOARD = 16,
	parameter int FIRST_SLOT         = 2,
	parameter int ENERGY_REBIN       = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [31:0]      cfg_wr_data,
	input  logic             step,
	input  logic [31:0]      word,
	output logic             has_result,
	output deb_pkg::result_t res
);

	logic [31:0] stash_q [3];
	logic [13:0] wpos_q;
	logic [13:0] evt_len_q;
	logic [4:0]  hdr_len_q;
	logic [47:0] ref_q;
	logic        have_ref_q;
	logic [31:0] window_q;

	deb_pkg::header_t hdr;
	logic        is_stash;
	logic        is_header;
	logic        is_sum;
	logic [13:0] evt_len_cur;
	logic        last;
	logic        ts_lt;
	logic [47:0] ts_diff;
	logic        new_ev;
	logic        oerr;

	deb_hdr_decode #(
		.BOARDS_PER_CRATE   (BOARDS_PER_CRATE),
		.CHANNELS_PER_BOARD (CHANNELS_PER_BOARD),
		.FIRST_SLOT         (FIRST_SLOT),
		.ENERGY_REBIN       (ENERGY_REBIN)
	) u_hdr_decode (
		.w0  (stash_q[0]),
		.w1  (stash_q[1]),
		.w2  (stash_q[2]),
		.w3  (word),
		.hdr (hdr)
	);

	assign is_stash    = wpos_q < deb_pkg::STASH_WORDS;
	assign is_header   = wpos_q == deb_pkg::HEADER_POS;
	assign is_sum      = wpos_q < {9'd0, hdr_len_q};
	assign has_result  = !is_stash;
	assign evt_len_cur = is_header ? hdr.evt_len : evt_len_q;
	assign last        = ({1'b0, wpos_q} + 15'd1) >= {1'b0, evt_len_cur};

	assign ts_lt   = hdr.timestamp < ref_q;
	assign ts_diff = hdr.timestamp - ref_q;
	assign new_ev  = !have_ref_q || (!ts_lt && (ts_diff > {16'd0, window_q}));
	assign oerr    = have_ref_q && ts_lt;

	always_comb begin
		res = '0;
		priority if (is_header) begin
			res.kind        = deb_pkg::KIND_HEADER;
			res.det_id      = hdr.det_id;
			res.pileup      = hdr.pileup;
			res.timestamp   = hdr.timestamp;
			res.cfd_time    = hdr.cfd_time;
			res.cfd_forced  = hdr.cfd_forced;
			res.energy      = hdr.energy;
			res.new_event   = new_ev;
			res.order_error = oerr;
		end else if (is_sum) begin
			if (hdr_len_q == deb_pkg::QDC_ONLY_HDR_LEN) begin
				res.kind = deb_pkg::KIND_QDC;
			end else if (wpos_q < deb_pkg::ESUM_END_POS) begin
				res.kind = deb_pkg::KIND_ESUM;
			end else begin
				res.kind = deb_pkg::KIND_QDC;
			end
			res.payload = word;
		end else begin
			res.kind    = deb_pkg::KIND_TRACE;
			res.payload = word & deb_pkg::TRACE_MASK;
		end
		res.last = last;
	end

	always_ff @(posedge clk) begin
		if (step && is_stash) begin
			stash_q[wpos_q[1:0]] <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q     <= '0;
			evt_len_q  <= '0;
			hdr_len_q  <= '0;
			ref_q      <= '0;
			have_ref_q <= 1'b0;
			window_q   <= deb_pkg::WINDOW_RESET;
		end else begin
			if (cfg_wr_en) begin
				window_q <= cfg_wr_data;
			end
			if (step) begin
				if (is_stash) begin
					wpos_q <= wpos_q + 14'd1;
				end else begin
					wpos_q <= last ? 14'd0 : wpos_q + 14'd1;
				end
				if (is_header) begin
					evt_len_q  <= hdr.evt_len;
					hdr_len_q  <= hdr.hdr_len;
					have_ref_q <= 1'b1;
					if (new_ev) begin
						ref_q <= hdr.timestamp;
					end
				end
			end
		end
	end

	a_last_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		step && has_result && res.last |=> wpos_q == 14'd0)
		else $error("word position not rewound after last word of subevent");

	a_hdr_within_evt: assert property (@(posedge clk) disable iff (!arst_n)
		{9'd0, hdr_len_q} <= evt_len_q)
		else $error("header length exceeds event length");

	a_new_event_ref: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_header && new_ev |=> have_ref_q && ref_q == $past(hdr.timestamp))
		else $error("reference time not taken from new event header");

endmodule

// ===== sv/digitizer_event_builder_top.sv =====
// Top level of the digitizer list-mode event builder.
// Input register, builder logic and result register. Depends on deb_pkg,
// deb_word_if, deb_result_if and deb_builder.
//
// Usage:
//   words   : one 32-bit list-mode word per transaction (valid/ready).
//   results : one result record per transaction (valid/ready); header words
//             zero to two of each subevent produce no result, every other word
//             produces exactly one.
//   cfg_wr_en/cfg_wr_data : write the build window (ticks); write only while idle.
// Throughput: one word per cycle while the receiver does not stall, set by the
//   single decode stage between the input register and the result register.
// Path: a taken word is held in the input register and its decoded result in the
//   result register (two register stages, input and result).
// Reset: build window returns to 100, word position to the start of a subevent,
//   and the builder forgets its reference time; the first header afterwards
//   starts a new event.
// Receiver stall: the result register holds its record; an empty input register
//   takes one more word, after which words.ready drops until results.ready rises.
module digitizer_event_builder_top #(
	parameter int BOARDS_PER_CRATE   = 13,
	parameter int CHANNELS_PER_BOARD = 16,
	parameter int FIRST_SLOT         = 2,
	parameter int ENERGY_REBIN       = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [31:0]  cfg_wr_data,
	deb_word_if.sink     words,
	deb_result_if.source results
);

	logic             valid_s1;
	logic [31:0]      word_s1;
	logic             valid_s2;
	deb_pkg::result_t res_s2;

	logic             load_s2;
	logic             adv_s1;
	logic             has_result;
	deb_pkg::result_t res;

	assign load_s2     = !valid_s2 || results.ready;
	assign adv_s1      = valid_s1 && load_s2;
	assign words.ready = !valid_s1 || load_s2;

	deb_builder #(
		.BOARDS_PER_CRATE   (BOARDS_PER_CRATE),
		.CHANNELS_PER_BOARD (CHANNELS_PER_BOARD),
		.FIRST_SLOT         (FIRST_SLOT),
		.ENERGY_REBIN       (ENERGY_REBIN)
	) u_builder (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (adv_s1),
		.word        (word_s1),
		.has_result  (has_result),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (words.ready) begin
				valid_s1 <= words.valid;
			end
			if (load_s2) begin
				valid_s2 <= adv_s1 && has_result;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (words.valid && words.ready) begin
			word_s1 <= words.data_word;
		end
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign results.valid       = valid_s2;
	assign results.kind        = res_s2.kind;
	assign results.det_id      = res_s2.det_id;
	assign results.pileup      = res_s2.pileup;
	assign results.timestamp   = res_s2.timestamp;
	assign results.cfd_time    = res_s2.cfd_time;
	assign results.cfd_forced  = res_s2.cfd_forced;
	assign results.energy      = res_s2.energy;
	assign results.new_event   = res_s2.new_event;
	assign results.order_error = res_s2.order_error;
	assign results.payload     = res_s2.payload;
	assign results.last        = res_s2.last;

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!words.ready |-> valid_s1 && valid_s2 && !results.ready)
		else $error("input held off while pipeline can advance");

	a_new_xor_order: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> !(results.new_event && results.order_error))
		else $error("result flagged both new event and order error");

	a_body_no_header: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.kind != deb_pkg::KIND_HEADER |->
			results.timestamp == 48'd0 && !results.new_event && !results.order_error)
		else $error("non-header result carries header fields");

endmodule

// ===== tb/tb_digitizer_event_builder_top.sv =====
`timescale 1ns / 100ps
// Testbench for digitizer_event_builder_top: drives list-mode subevents, predicts
// every result record in a scoreboard class and checks the result stream field by field.
// Depends on deb_pkg, deb_word_if, deb_result_if and the RTL of the event builder.
module tb_digitizer_event_builder_top;

	localparam int BOARDS_PER_CRATE   = 13;
	localparam int CHANNELS_PER_BOARD = 16;
	localparam int FIRST_SLOT         = 2;
	localparam int ENERGY_REBIN       = 1;
	localparam int PHASE_WORDS        = 230;
	localparam int HOLD_CYCLES        = 300;
	localparam int CYCLE_LIMIT        = 600000;

	class event_scoreboard;
		logic [13:0] word_pos;
		logic [13:0] subevent_len;
		logic [4:0]  header_len;
		logic [31:0] stash [3];
		logic [47:0] ref_time;
		logic        have_ref;
		logic [31:0] window;
		deb_pkg::result_t pending_records [$];
		int unsigned errors;

		function new();
			word_pos = '0;
			subevent_len = '0;
			header_len = '0;
			foreach (stash[i]) stash[i] = '0;
			ref_time = '0;
			have_ref = 1'b0;
			window = deb_pkg::WINDOW_RESET;
			errors = 0;
		endfunction

		function void record_word(logic [31:0] w);
			deb_pkg::result_t rec;
			logic [31:0] w0;
			logic [13:0] el;
			logic [4:0]  hl;
			logic [47:0] ts;
			logic [13:0] pos;
			int unsigned crate_n, slot_n, chan_n, id;
			pos = word_pos;
			if (pos < deb_pkg::STASH_WORDS) begin
				stash[pos[1:0]] = w;
				word_pos = pos + 14'd1;
				return;
			end
			rec = '0;
			if (pos == deb_pkg::HEADER_POS) begin
				w0 = stash[0];
				el = w0[30:17];
				hl = w0[16:12];
				if (el < deb_pkg::MIN_EVT_LEN) el = deb_pkg::MIN_EVT_LEN;
				if (hl < deb_pkg::MIN_HDR_LEN) hl = deb_pkg::MIN_HDR_LEN;
				if ({9'd0, hl} > el) hl = el[4:0];
				subevent_len = el;
				header_len = hl;
				ts = {stash[2][15:0], stash[1]};
				chan_n = {28'd0, w0[3:0]};
				slot_n = {28'd0, w0[7:4]};
				crate_n = {28'd0, w0[11:8]};
				id = crate_n * BOARDS_PER_CRATE * CHANNELS_PER_BOARD
					+ (slot_n - FIRST_SLOT) * CHANNELS_PER_BOARD + chan_n;
				rec.kind = deb_pkg::KIND_HEADER;
				rec.det_id = id[11:0];
				rec.pileup = w0[31];
				rec.timestamp = ts;
				rec.cfd_time = stash[2][30:16];
				rec.cfd_forced = stash[2][31];
				rec.energy = 16'({16'd0, w[15:0]} / 32'(ENERGY_REBIN));
				if (!have_ref) begin
					rec.new_event = 1'b1;
					ref_time = ts;
					have_ref = 1'b1;
				end else if (ts < ref_time) begin
					rec.order_error = 1'b1;
				end else if (ts - ref_time > {16'd0, window}) begin
					rec.new_event = 1'b1;
					ref_time = ts;
				end
			end else if (pos < {9'd0, header_len}) begin
				if (header_len == deb_pkg::QDC_ONLY_HDR_LEN || pos >= deb_pkg::ESUM_END_POS)
					rec.kind = deb_pkg::KIND_QDC;
				else
					rec.kind = deb_pkg::KIND_ESUM;
				rec.payload = w;
			end else begin
				rec.kind = deb_pkg::KIND_TRACE;
				rec.payload = w & deb_pkg::TRACE_MASK;
			end
			rec.last = ({1'b0, pos} + 15'd1) >= {1'b0, subevent_len};
			word_pos = rec.last ? 14'd0 : pos + 14'd1;
			pending_records.push_back(rec);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_record(deb_pkg::result_t got);
			deb_pkg::result_t want;
			if (pending_records.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending_records.pop_front();
			compare_field("kind", 64'(want.kind), 64'(got.kind));
			compare_field("det_id", 64'(want.det_id), 64'(got.det_id));
			compare_field("pileup", 64'(want.pileup), 64'(got.pileup));
			compare_field("timestamp", 64'(want.timestamp), 64'(got.timestamp));
			compare_field("cfd_time", 64'(want.cfd_time), 64'(got.cfd_time));
			compare_field("cfd_forced", 64'(want.cfd_forced), 64'(got.cfd_forced));
			compare_field("energy", 64'(want.energy), 64'(got.energy));
			compare_field("new_event", 64'(want.new_event), 64'(got.new_event));
			compare_field("order_error", 64'(want.order_error), 64'(got.order_error));
			compare_field("payload", 64'(want.payload), 64'(got.payload));
			compare_field("last", 64'(want.last), 64'(got.last));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;
	bit          sender_idles;
	bit          receiver_idles;
	bit          hold_results;
	bit          hold_taken;
	int unsigned cycle_count;
	event_scoreboard sb;

	deb_word_if   words_ch ();
	deb_result_if results_ch ();

	digitizer_event_builder_top #(
		.BOARDS_PER_CRATE   (BOARDS_PER_CRATE),
		.CHANNELS_PER_BOARD (CHANNELS_PER_BOARD),
		.FIRST_SLOT         (FIRST_SLOT),
		.ENERGY_REBIN       (ENERGY_REBIN)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.words       (words_ch),
		.results     (results_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (words_ch.valid && words_ch.ready)
				sb.record_word(words_ch.data_word);
			if (results_ch.valid && results_ch.ready)
				sb.check_record({results_ch.kind, results_ch.det_id, results_ch.pileup,
					results_ch.timestamp, results_ch.cfd_time, results_ch.cfd_forced,
					results_ch.energy, results_ch.new_event, results_ch.order_error,
					results_ch.payload, results_ch.last});
		end
	end

	// result receiver: random stalls, plus one long hold-off on request
	initial begin
		int unsigned stall;
		results_ch.ready <= 1'b0;
		forever begin
			if (hold_results && !hold_taken) begin
				hold_taken = 1'b1;
				results_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = receiver_idles ? $urandom_range(0, 9) : 0;
			if (stall != 0) begin
				results_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results_ch.ready <= 1'b1;
			@(posedge clk);
			while (!results_ch.valid) @(posedge clk);
		end
	end

	task automatic send_word(input logic [31:0] w);
		int unsigned gap;
		gap = sender_idles ? $urandom_range(0, 9) : 0;
		if (gap != 0) begin
			words_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		words_ch.valid <= 1'b1;
		words_ch.data_word <= w;
		@(posedge clk);
		while (!words_ch.ready) @(posedge clk);
	endtask

	task automatic drain_results();
		words_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_records.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window(input logic [31:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.window = value;
	endtask

	function automatic logic [31:0] make_header0(logic pileup, logic [13:0] el,
		logic [4:0] hl, logic [3:0] crate, logic [3:0] slot, logic [3:0] chan);
		return {pileup, el, hl, crate, slot, chan};
	endfunction

	function automatic logic [31:0] random_payload();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// timestamp mostly relative to the current reference, hitting the window edges
	function automatic logic [47:0] pick_stamp();
		logic [47:0] base;
		base = sb.ref_time;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return base + 48'($urandom_range(0, 120));
			4: return base + {16'd0, sb.window};
			5: return base + {16'd0, sb.window} + 48'd1;
			6: return base - 48'($urandom_range(1, 300));
			7: return {16'($urandom), $urandom};
			8: return base + {16'd0, $urandom};
			default: return base + {14'd0, 2'($urandom_range(0, 3)), $urandom};
		endcase
	endfunction

	task automatic send_subevent(input logic [31:0] w0, input logic [47:0] stamp,
		input bit random_stamp, input logic [15:0] w2_hi, input logic [31:0] w3,
		output int unsigned n_words);
		logic [47:0] ts;
		logic [13:0] el_eff;
		el_eff = (w0[30:17] < deb_pkg::MIN_EVT_LEN) ? deb_pkg::MIN_EVT_LEN : w0[30:17];
		send_word(w0);
		ts = random_stamp ? pick_stamp() : stamp;
		send_word(ts[31:0]);
		send_word({w2_hi, ts[47:32]});
		send_word(w3);
		for (int i = 4; i < int'(el_eff); i++)
			send_word(random_payload());
		n_words = 32'(el_eff);
	endtask

	task automatic send_random_subevent(output int unsigned n_words);
		logic [13:0] el;
		logic [4:0]  hl;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			el = 14'($urandom_range(0, 16));
		else if (pick < 9)
			el = 14'($urandom_range(17, 40));
		else
			el = 14'($urandom_range(0, 64));
		hl = ($urandom_range(0, 3) == 0) ? deb_pkg::QDC_ONLY_HDR_LEN
			: 5'($urandom_range(0, 31));
		if (hl == deb_pkg::QDC_ONLY_HDR_LEN && el < 14'd12)
			el = 14'($urandom_range(12, 24));
		send_subevent(make_header0(1'($urandom_range(0, 1)), el, hl, 4'($urandom),
			4'($urandom), 4'($urandom)), 48'd0, 1'b1, 16'($urandom), $urandom, n_words);
	endtask

	initial begin
		int unsigned n, phase_count;
		logic [31:0] win;
		sb = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		words_ch.valid = 1'b0;
		words_ch.data_word = '0;
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		hold_results = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first header, window edge, window exceeded, out of order, extremes
		send_subevent(make_header0(1'b0, 14'd0, 5'd0, 4'd0, 4'd0, 4'd0),
			48'd0, 1'b0, 16'h0000, 32'h0000_0000, n);
		send_subevent(make_header0(1'b0, 14'd1, 5'd3, 4'd0, 4'd2, 4'd0),
			48'd100, 1'b0, 16'h0001, 32'hA5A5_0001, n);
		send_subevent(make_header0(1'b1, 14'd2, 5'd4, 4'd1, 4'd3, 4'd5),
			48'd101, 1'b0, 16'h8000, 32'h0000_8000, n);
		send_subevent(make_header0(1'b1, 14'd5, 5'd5, 4'hF, 4'hF, 4'hF),
			48'd50, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, n);
		send_subevent(make_header0(1'b0, 14'd6, 5'd4, 4'h7, 4'h1, 4'hA),
			48'hFFFF_FFFF_FFFF, 1'b0, 16'h7FFF, 32'h5A5A_7FFF, n);
		drain_results();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: win = 32'd0;
				1: win = 32'hFFFF_FFFF;
				2: win = 32'd1;
				3: win = $urandom;
				4: win = $urandom_range(50, 5000);
				default: win = deb_pkg::WINDOW_RESET;
			endcase
			write_window(win);
			sender_idles = (p != 1 && p != 5);
			receiver_idles = (p != 2 && p != 5);
			phase_count = 0;
			if (p == 5) begin
				send_subevent(make_header0(1'($urandom_range(0, 1)), 14'd160,
					5'($urandom), 4'($urandom), 4'($urandom), 4'($urandom)),
					48'd0, 1'b1, 16'($urandom), $urandom, n);
				sender_idles = 1'b1;
				receiver_idles = 1'b1;
			end
			while (phase_count < PHASE_WORDS) begin
				if (p == 3 && phase_count >= 40)
					hold_results = 1'b1;
				send_random_subevent(n);
				phase_count += n;
			end
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_records.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/deb_pkg.sv
sv/deb_word_if.sv
sv/deb_result_if.sv
sv/deb_hdr_decode.sv
sv/deb_builder.sv
sv/digitizer_event_builder_top.sv
tb/tb_digitizer_event_builder_top.sv
